[rtl/lcg_pkg.sv]
// Shared types and constants for the level-to-color gradient block.
// No dependencies; every other rtl file imports this package.
`default_nettype none

package lcg_pkg;

  // Breakpoint table size and derived widths
  localparam int NUM_POINTS = 5;
  localparam int KW         = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
  localparam int CFG_IDX_W  = KW;

  localparam int THR_W = 16;
  localparam int COL_W = 24;
  localparam int BP_W  = THR_W + COL_W;
  localparam int CH_W  = 8;
  localparam int NUM_W = CH_W + THR_W;

  // Pipeline shape: select, differences, products, sum, then the divider
  localparam int DIV_BITS   = 2;
  localparam int DIV_STAGES = CH_W / DIV_BITS;
  localparam int DIV_FIRST  = 4;
  localparam int NSTAGE     = DIV_FIRST + DIV_STAGES;

  typedef logic [THR_W-1:0]     thr_t;
  typedef logic [COL_W-1:0]     col_t;
  typedef logic [BP_W-1:0]      bp_t;
  typedef logic [CH_W-1:0]      ch_t;
  typedef logic [NUM_W-1:0]     num_t;
  typedef logic [KW-1:0]        pt_idx_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Per-stage load enables from the pipeline control
  typedef struct packed {
    logic [NSTAGE-1:0] en;
  } stage_ctrl_t;

  // Breakpoint values after reset: {threshold, RRGGBB}
  localparam bp_t RESET_BP [8] = '{
    {16'd400,  24'h008000},
    {16'd800,  24'hFFFF00},
    {16'd1200, 24'hFFA500},
    {16'd2000, 24'hFF0000},
    {16'd3000, 24'h800080},
    {16'd3000, 24'h800080},
    {16'd3000, 24'h800080},
    {16'd3000, 24'h800080}
  };

endpackage

`default_nettype wire

[rtl/lcg_ctrl.sv]
// Valid bits and per-stage load enables for the gradient pipeline.
// Depends on lcg_pkg.
`default_nettype none

module lcg_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output lcg_pkg::stage_ctrl_t     ctrl
);
  import lcg_pkg::*;

  logic [NSTAGE-1:0] v;
  logic [NSTAGE-1:0] vin;

  // A stage loads when it is empty or its successor loads
  always_comb begin
    ctrl.en[NSTAGE-1] = !v[NSTAGE-1] || out_ready;
    for (int i = NSTAGE-2; i >= 0; i--) begin
      ctrl.en[i] = !v[i] || ctrl.en[i+1];
    end
  end

  assign vin       = {v[NSTAGE-2:0], in_valid};
  assign in_ready  = ctrl.en[0];
  assign out_valid = v[NSTAGE-1];

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < NSTAGE; i++) begin
        if (ctrl.en[i]) begin
          v[i] <= vin[i];
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/lcg_select.sv]
// Breakpoint registers and segment search: first pipeline stage.
// Depends on lcg_pkg.
`default_nettype none

module lcg_select (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire lcg_pkg::cfg_idx_t cfg_index,
  input  wire lcg_pkg::bp_t      cfg_data,
  input  wire logic              en,
  input  wire lcg_pkg::thr_t     level,
  output lcg_pkg::thr_t          seg_lo,
  output lcg_pkg::thr_t          seg_hi,
  output lcg_pkg::thr_t          seg_x,
  output lcg_pkg::col_t          seg_lc,
  output lcg_pkg::col_t          seg_hc
);
  import lcg_pkg::*;

  bp_t     bp [NUM_POINTS];
  thr_t    thr [NUM_POINTS];
  col_t    col [NUM_POINTS];
  pt_idx_t k;
  pt_idx_t km1;
  thr_t    lo_next, hi_next, x_next;
  col_t    lc_next, hc_next;

  // Hold configured breakpoints; ignore indexes past the table
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_POINTS; i++) begin
        bp[i] <= RESET_BP[i % 8];
      end
    end else if (cfg_we && (int'(cfg_index) < NUM_POINTS)) begin
      bp[cfg_index[KW-1:0]] <= cfg_data;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_POINTS; i++) begin
      thr[i] = bp[i][BP_W-1:COL_W];
      col[i] = bp[i][COL_W-1:0];
    end
  end

  // Find first threshold above the level; clamped ends use a unit segment
  // with equal colors so the later stages pass the color through unchanged
  always_comb begin
    k = pt_idx_t'(NUM_POINTS - 1);
    for (int i = NUM_POINTS - 1; i >= 1; i--) begin
      if (thr[i] > level) begin
        k = pt_idx_t'(i);
      end
    end
    km1 = k - pt_idx_t'(1);
    if (level <= thr[0]) begin
      lo_next = '0;
      hi_next = thr_t'(1);
      x_next  = '0;
      lc_next = col[0];
      hc_next = col[0];
    end else if (level >= thr[NUM_POINTS-1]) begin
      lo_next = '0;
      hi_next = thr_t'(1);
      x_next  = '0;
      lc_next = col[NUM_POINTS-1];
      hc_next = col[NUM_POINTS-1];
    end else begin
      lo_next = thr[km1];
      hi_next = thr[k];
      x_next  = level;
      lc_next = col[km1];
      hc_next = col[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seg_lo <= lo_next;
      seg_hi <= hi_next;
      seg_x  <= x_next;
      seg_lc <= lc_next;
      seg_hc <= hc_next;
    end
  end

endmodule

`default_nettype wire

[rtl/lcg_interp.sv]
// Interpolation numerators for three channels: differences, products, sum.
// Depends on lcg_pkg; pipeline stages one to three.
`default_nettype none

module lcg_interp (
  input  wire logic          clk,
  input  wire lcg_pkg::stage_ctrl_t ctrl,
  input  wire lcg_pkg::thr_t seg_lo,
  input  wire lcg_pkg::thr_t seg_hi,
  input  wire lcg_pkg::thr_t seg_x,
  input  wire lcg_pkg::col_t seg_lc,
  input  wire lcg_pkg::col_t seg_hc,
  output lcg_pkg::num_t      num [3],
  output lcg_pkg::thr_t      dvsr
);
  import lcg_pkg::*;

  // Low end never exceeds the level and the high end is above it,
  // so all three differences stay non-negative and the divisor nonzero
  thr_t s1_d, s1_dh, s1_dl;
  col_t s1_lc, s1_hc;
  num_t s2_pa [3];
  num_t s2_pb [3];
  thr_t s2_d;

  // Stage one: segment width and distances to both ends
  always_ff @(posedge clk) begin
    if (ctrl.en[1]) begin
      s1_d  <= seg_hi - seg_lo;
      s1_dh <= seg_hi - seg_x;
      s1_dl <= seg_x - seg_lo;
      s1_lc <= seg_lc;
      s1_hc <= seg_hc;
    end
  end

  // Stage two: weight each end color
  for (genvar c = 0; c < 3; c++) begin : g_prod
    always_ff @(posedge clk) begin
      if (ctrl.en[2]) begin
        s2_pa[c] <= num_t'(s1_lc[COL_W-1-CH_W*c -: CH_W]) * num_t'(s1_dh);
        s2_pb[c] <= num_t'(s1_hc[COL_W-1-CH_W*c -: CH_W]) * num_t'(s1_dl);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[2]) begin
      s2_d <= s1_d;
    end
  end

  // Stage three: numerator, bounded by 255 times the divisor
  for (genvar c = 0; c < 3; c++) begin : g_sum
    always_ff @(posedge clk) begin
      if (ctrl.en[3]) begin
        num[c] <= s2_pa[c] + s2_pb[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[3]) begin
      dvsr <= s2_d;
    end
  end

endmodule

`default_nettype wire

[rtl/lcg_div.sv]
// Pipelined restoring divider, two quotient bits per stage, one channel.
// Depends on lcg_pkg; the quotient is known to fit in one channel.
`default_nettype none

module lcg_div (
  input  wire logic          clk,
  input  wire lcg_pkg::stage_ctrl_t ctrl,
  input  wire lcg_pkg::num_t num,
  input  wire lcg_pkg::thr_t dvsr,
  output lcg_pkg::ch_t       quo
);
  import lcg_pkg::*;

  num_t rem_q [DIV_STAGES];
  ch_t  quo_q [DIV_STAGES];
  thr_t d_q   [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    num_t rem_in;
    ch_t  quo_in;
    thr_t d_in;
    num_t rem_next;
    ch_t  quo_next;

    if (s == 0) begin : g_head
      assign rem_in = num;
      assign quo_in = '0;
      assign d_in   = dvsr;
    end else begin : g_body
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
      assign d_in   = d_q[s-1];
    end

    // Trial-subtract the shifted divisor for this stage's quotient bits
    always_comb begin
      int   j;
      num_t dsh;
      rem_next = rem_in;
      quo_next = quo_in;
      for (int b = 0; b < DIV_BITS; b++) begin
        j   = CH_W - 1 - DIV_BITS * s - b;
        dsh = num_t'(d_in) << j;
        if (rem_next >= dsh) begin
          rem_next = rem_next - dsh;
          quo_next[j] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ctrl.en[DIV_FIRST + s]) begin
        rem_q[s] <= rem_next;
        quo_q[s] <= quo_next;
        d_q[s]   <= d_in;
      end
    end
  end

  assign quo = quo_q[DIV_STAGES-1];

endmodule

`default_nettype wire

[rtl/level_to_color_gradient.sv]
// Top level of the level-to-color gradient map.
// Depends on lcg_pkg, lcg_ctrl, lcg_select, lcg_interp and lcg_div.
//
//   Channel   Handshake                Payload
//   input     in_valid / in_ready      level
//   output    out_valid / out_ready    red, green, blue
//   config    cfg_we (no handshake)    cfg_index, cfg_data
//
// One transaction enters per cycle unless a stall drops in_ready; results
// pass segment search, differences, products, sum, four divider stages.
// The divider's four stages, two quotient bits each, set the depth.
// Reset loads the default breakpoints and empties the pipeline.
// A stall holds only the stages that are full; empty stages keep filling.
`default_nettype none

module level_to_color_gradient (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire lcg_pkg::thr_t     level,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output lcg_pkg::ch_t           red,
  output lcg_pkg::ch_t           green,
  output lcg_pkg::ch_t           blue,
  input  wire logic              cfg_we,
  input  wire lcg_pkg::cfg_idx_t cfg_index,
  input  wire lcg_pkg::bp_t      cfg_data
);
  import lcg_pkg::*;

  stage_ctrl_t ctrl;
  thr_t        seg_lo, seg_hi, seg_x;
  col_t        seg_lc, seg_hc;
  num_t        num [3];
  thr_t        dvsr;
  ch_t         quo [3];

  // Pipeline valid bits and stall chain
  lcg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctrl      (ctrl)
  );

  // Breakpoints and segment search
  lcg_select u_select (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .en        (ctrl.en[0]),
    .level     (level),
    .seg_lo    (seg_lo),
    .seg_hi    (seg_hi),
    .seg_x     (seg_x),
    .seg_lc    (seg_lc),
    .seg_hc    (seg_hc)
  );

  // Per-channel numerators and shared divisor
  lcg_interp u_interp (
    .clk    (clk),
    .ctrl   (ctrl),
    .seg_lo (seg_lo),
    .seg_hi (seg_hi),
    .seg_x  (seg_x),
    .seg_lc (seg_lc),
    .seg_hc (seg_hc),
    .num    (num),
    .dvsr   (dvsr)
  );

  // One divider per channel
  for (genvar c = 0; c < 3; c++) begin : g_div
    lcg_div u_div (
      .clk  (clk),
      .ctrl (ctrl),
      .num  (num[c]),
      .dvsr (dvsr),
      .quo  (quo[c])
    );
  end

  assign red   = quo[0];
  assign green = quo[1];
  assign blue  = quo[2];

endmodule

`default_nettype wire
